// File: hdl/quoted_argument_tokenizer_macros.svh
// Assertion macros for the command-line tokenizer.
// Used by the top level only; needs clk and rst in scope.
`ifndef QUOTED_ARGUMENT_TOKENIZER_MACROS_SVH
`define QUOTED_ARGUMENT_TOKENIZER_MACROS_SVH

// same-cycle implication
`define QAT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qat assertion failed");

// next-cycle implication
`define QAT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qat assertion failed");

`endif

// File: hdl/qat_pkg.sv
// Shared types and constants for the command-line tokenizer.
// No dependencies.
package qat_pkg;

  localparam logic [7:0] CH_SQUOTE  = 8'h27;
  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_LOWER_S = 8'h73;

  localparam logic [1:0] PH_NONE = 2'd0;
  localparam logic [1:0] PH_OPEN = 2'd1;
  localparam logic [1:0] PH_DONE = 2'd2;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_ESCAPE  = 3'd1,
    ST_UNTERM      = 3'd2,
    ST_EMPTY_ARGV  = 3'd3,
    ST_NUL         = 3'd4,
    ST_NO_PLACEHLD = 3'd5,
    ST_NOT_ABS     = 3'd6
  } status_t;

  typedef struct packed {
    logic       in_single_quote;
    logic       in_double_quote;
    logic       escape_pending;
    logic       argument_open;
    logic       previous_was_percent;
    logic       placeholder_seen;
    logic       nul_seen;
    logic       bad_escape_seen;
    logic [1:0] first_argument_phase;
    logic       first_char_is_slash;
    logic       first_arg_nonempty;
  } qat_state_t;

  localparam qat_state_t STATE_RESET = '0;

  typedef struct packed {
    logic       byte_present;
    logic [7:0] byte_value;
    logic       is_last;
  } qat_item_t;

  typedef struct packed {
    logic       char_valid;
    logic [7:0] out_char;
    logic       arg_end;
    logic       done_res;
  } qat_result_t;

endpackage

// File: hdl/quoted_argument_tokenizer.sv
// Shell-style command-line tokenizer: one input word in, one result word out.
// Each input word is registered in in_reg, and its result word in out_reg.
// Throughput: one word per cycle while out_stall is low; the parse state register closes the only loop.
// Reset (rst, synchronous): clears parse state and both stage valid flags.
// After each word marked is_last the parse state returns to its reset value.
`include "quoted_argument_tokenizer_macros.svh"
module quoted_argument_tokenizer (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       byte_present,
  input  logic [7:0] byte_value,
  input  logic       is_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       char_valid,
  output logic [7:0] out_char,
  output logic       arg_end,
  output logic       done_res,
  output logic [2:0] status
);
  import qat_pkg::*;

  qat_item_t   in_reg;
  logic        in_reg_valid;
  qat_state_t  st;
  qat_state_t  st_post;
  qat_state_t  st_next;
  qat_result_t res;
  qat_result_t out_reg;
  status_t     res_status;
  status_t     out_status;
  logic        advance;

  assign advance  = !out_valid || !out_stall;
  assign in_stall = in_reg_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (!in_stall) begin
      in_reg_valid <= in_valid;
    end
    if (!in_stall && in_valid) begin
      in_reg <= '{byte_present: byte_present, byte_value: byte_value, is_last: is_last};
    end
  end

  qat_parse u_parse (
    .st      (st),
    .item    (in_reg),
    .st_post (st_post),
    .res     (res)
  );

  qat_status u_status (
    .st_post (st_post),
    .is_last (in_reg.is_last),
    .status  (res_status)
  );

  assign st_next = in_reg.is_last ? STATE_RESET : st_post;

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= STATE_RESET;
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_reg_valid;
      if (in_reg_valid) begin
        st <= st_next;
      end
    end
    if (advance && in_reg_valid) begin
      out_reg    <= res;
      out_status <= res_status;
    end
  end

  assign char_valid = out_reg.char_valid;
  assign out_char   = out_reg.out_char;
  assign arg_end    = out_reg.arg_end;
  assign done_res   = out_reg.done_res;
  assign status     = out_status;

  `QAT_ASSERT_NEXT(a_reset_after_last, advance && in_reg_valid && in_reg.is_last,
                   st == STATE_RESET)
  `QAT_ASSERT_NEXT(a_char_opens_arg,
                   advance && in_reg_valid && res.char_valid && !in_reg.is_last,
                   st.argument_open)
  `QAT_ASSERT_IMP(a_status_only_done, out_valid && !done_res, status == ST_OK)
  `QAT_ASSERT_IMP(a_phase_range, 1'b1, st.first_argument_phase != 2'd3)

endmodule

// File: hdl/qat_parse.sv
// Per-byte tokenizer step: quote/escape handling, argument open/close, flags.
// Depends on qat_pkg.
module qat_parse (
  input  qat_pkg::qat_state_t  st,
  input  qat_pkg::qat_item_t   item,
  output qat_pkg::qat_state_t  st_post,
  output qat_pkg::qat_result_t res
);
  import qat_pkg::*;

  logic [7:0] c;
  logic       do_open;
  logic       do_append;
  logic       do_close;
  logic       blank;
  logic       unterm;

  assign c = item.byte_value;

  always_comb begin
    blank = c inside {8'h20, 8'h09, 8'h0D, 8'h0A, 8'h0C, 8'h0B};
  end

  always_comb begin
    st_post   = st;
    do_open   = 1'b0;
    do_append = 1'b0;
    do_close  = 1'b0;
    res       = '0;

    if (item.byte_present) begin
      if (st.escape_pending) begin
        st_post.escape_pending = 1'b0;
        if (st.in_double_quote && c != CH_DQUOTE && c != CH_BSLASH) begin
          st_post.bad_escape_seen = 1'b1;
        end else begin
          do_append = 1'b1;
        end
      end else if (st.in_single_quote) begin
        if (c == CH_SQUOTE) begin
          st_post.in_single_quote = 1'b0;
          do_open = 1'b1;
        end else begin
          do_append = 1'b1;
        end
      end else if (st.in_double_quote) begin
        if (c == CH_DQUOTE) begin
          st_post.in_double_quote = 1'b0;
          do_open = 1'b1;
        end else if (c == CH_BSLASH) begin
          st_post.escape_pending = 1'b1;
        end else begin
          do_append = 1'b1;
        end
      end else if (c == CH_SQUOTE) begin
        st_post.in_single_quote = 1'b1;
        do_open = 1'b1;
      end else if (c == CH_DQUOTE) begin
        st_post.in_double_quote = 1'b1;
        do_open = 1'b1;
      end else if (c == CH_BSLASH) begin
        st_post.escape_pending = 1'b1;
        do_open = 1'b1;
      end else if (blank) begin
        do_close = st.argument_open;
      end else begin
        do_append = 1'b1;
      end
    end

    // open (also implied by append)
    if ((do_open || do_append) && !st_post.argument_open) begin
      st_post.argument_open = 1'b1;
      if (st_post.first_argument_phase == PH_NONE) begin
        st_post.first_argument_phase = PH_OPEN;
      end
    end

    if (do_append) begin
      res.char_valid = 1'b1;
      res.out_char   = c;
      if (c == 8'h00) begin
        st_post.nul_seen = 1'b1;
      end
      if (st_post.previous_was_percent && c == CH_LOWER_S) begin
        st_post.placeholder_seen = 1'b1;
      end
      st_post.previous_was_percent = (c == CH_PERCENT);
      if (st_post.first_argument_phase == PH_OPEN && !st_post.first_arg_nonempty) begin
        st_post.first_arg_nonempty  = 1'b1;
        st_post.first_char_is_slash = (c == CH_SLASH);
      end
    end

    unterm = st_post.escape_pending || st_post.in_single_quote || st_post.in_double_quote;

    // end of command closes an open argument unless quoting or an escape is still open
    if (item.is_last && st_post.argument_open && !unterm) begin
      do_close = 1'b1;
    end

    if (do_close) begin
      st_post.argument_open        = 1'b0;
      st_post.previous_was_percent = 1'b0;
      if (st_post.first_argument_phase == PH_OPEN) begin
        st_post.first_argument_phase = PH_DONE;
      end
      res.arg_end = 1'b1;
    end

    res.done_res = item.is_last;
  end

endmodule

// File: hdl/qat_status.sv
// Final checks on the end of a command, reported by priority.
// Depends on qat_pkg.
module qat_status (
  input  qat_pkg::qat_state_t st_post,
  input  logic                is_last,
  output qat_pkg::status_t    status
);
  import qat_pkg::*;

  always_comb begin
    if (!is_last) begin
      status = ST_OK;
    end else if (st_post.bad_escape_seen) begin
      status = ST_BAD_ESCAPE;
    end else if (st_post.escape_pending || st_post.in_single_quote ||
                 st_post.in_double_quote) begin
      status = ST_UNTERM;
    end else if (!st_post.first_arg_nonempty) begin
      status = ST_EMPTY_ARGV;
    end else if (st_post.nul_seen) begin
      status = ST_NUL;
    end else if (!st_post.placeholder_seen) begin
      status = ST_NO_PLACEHLD;
    end else if (!st_post.first_char_is_slash) begin
      status = ST_NOT_ABS;
    end else begin
      status = ST_OK;
    end
  end

endmodule
